>>> hw/rtl/sorted_key_table_insert_update_assert.svh
// assertion macros for the sorted key table
`ifndef SORTED_KEY_TABLE_INSERT_UPDATE_ASSERT_SVH
`define SORTED_KEY_TABLE_INSERT_UPDATE_ASSERT_SVH

// antecedent implies consequent on the next edge
`define SKT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// condition holds at every edge out of reset
`define SKT_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

`endif

>>> hw/rtl/skt_pkg.sv
`default_nettype none
package skt_pkg;
    localparam int TableEntries = 1024;
    localparam int YearSlots    = 10;
    localparam int PosW         = 10;
    localparam int CntW         = 11;
    localparam int SlotW        = 4;
    localparam int CountAddrW   = 14;
    localparam logic [15:0] BaseYearReset = 16'd2009;

    // controller to datapath
    typedef struct packed {
        logic load;        // capture the request
        logic probe_rd;    // read keys at mid
        logic probe_eval;  // compare probe and narrow range
        logic shift_rd;    // read entry src for the move
        logic shift_wr;    // write read entry to src+1
        logic clr_wr;      // write zero to count slot of new entry
        logic key_wr;      // write key and bump count
        logic upd_wr;      // write count at pos/slot
        logic rd_issue;    // read for a read request
        logic finish;      // present result
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic kind;
        logic search_done;
        logic found;
        logic bad_year;
        logic full;
        logic shift_last;  // src reached pos
        logic no_shift;    // nothing to move
        logic clr_last;
    } t_stat;
endpackage
`default_nettype wire

>>> hw/rtl/skt_ctrl.sv
`default_nettype none
module skt_ctrl
    import skt_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  start,
    output logic       busy,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd
);
    localparam logic [3:0] S_IDLE = 4'd0, S_PRD = 4'd1, S_PEV = 4'd2, S_DEC = 4'd3,
        S_SRD = 4'd4, S_SWR = 4'd5, S_CLR = 4'd6, S_KEY = 4'd7, S_UPD = 4'd8,
        S_RD = 4'd9, S_RDW = 4'd10, S_FIN = 4'd11;

    logic [3:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state = S_PRD;
                end
            end
            S_PRD: begin
                if (i_stat.kind) n_state = S_RD;
                else if (i_stat.search_done) n_state = S_DEC;
                else begin
                    o_cmd.probe_rd = 1'b1;
                    n_state = S_PEV;
                end
            end
            S_PEV: begin
                o_cmd.probe_eval = 1'b1;
                n_state = S_PRD;
            end
            S_DEC: begin
                if (i_stat.bad_year || i_stat.full) n_state = S_FIN;
                else if (i_stat.found) n_state = S_UPD;
                else if (i_stat.no_shift) n_state = S_CLR;
                else n_state = S_SRD;
            end
            S_SRD: begin
                o_cmd.shift_rd = 1'b1;
                n_state = S_SWR;
            end
            S_SWR: begin
                o_cmd.shift_wr = 1'b1;
                n_state = i_stat.shift_last ? S_CLR : S_SRD;
            end
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_stat.clr_last) n_state = S_KEY;
            end
            S_KEY: begin
                o_cmd.key_wr = 1'b1;
                n_state = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd_wr = 1'b1;
                n_state = S_FIN;
            end
            S_RD: begin
                o_cmd.rd_issue = 1'b1;
                n_state = S_RDW;
            end
            S_RDW: n_state = S_FIN;
            S_FIN: begin
                o_cmd.finish = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign busy = (r_state != S_IDLE);
endmodule
`default_nettype wire

>>> hw/rtl/skt_dp.sv
`default_nettype none
module skt_dp
    import skt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    output t_stat            o_stat,
    input  wire logic [15:0] i_base_year,
    input  wire logic        i_kind,
    input  wire logic [15:0] i_year,
    input  wire logic [63:0] i_key_bytes_first,
    input  wire logic [63:0] i_key_bytes_middle,
    input  wire logic [23:0] i_key_bytes_last,
    input  wire logic [7:0]  i_sex_code,
    input  wire logic [23:0] i_count,
    input  wire logic [9:0]  i_read_position,
    input  wire logic [3:0]  i_read_slot,
    output logic             o_done,
    output logic [10:0]      o_position,
    output logic             o_already_present,
    output logic             o_table_full,
    output logic             o_year_out_of_range,
    output logic [63:0]      o_out_key_first,
    output logic [63:0]      o_out_key_middle,
    output logic [23:0]      o_out_key_last,
    output logic [7:0]       o_out_sex,
    output logic [23:0]      o_out_count,
    output logic             o_entry_valid,
    output logic [10:0]      o_entries_used
);
    // memories
    logic [63:0] r_mem_first [TableEntries];
    logic [63:0] r_mem_mid   [TableEntries];
    logic [31:0] r_mem_tail  [TableEntries];
    logic [23:0] r_mem_cnt   [TableEntries*YearSlots];

    logic [CntW-1:0] r_used;
    logic            r_kind;
    logic [63:0]     r_kf, r_km;
    logic [31:0]     r_kt;
    logic [23:0]     r_cnt;
    logic [9:0]      r_rpos;
    logic [3:0]      r_rslot;
    logic [CntW-1:0] r_lo, r_hi;
    logic            r_found, r_bad, r_slot_ok;
    logic            r_full;  // table was at capacity when the request arrived
    logic [SlotW-1:0] r_slot;
    logic [CntW-1:0] r_src;   // entry being moved, counts down
    logic [SlotW-1:0] r_sidx; // year slot inside a move or clear
    logic [63:0]     r_rd_f, r_rd_m;
    logic [31:0]     r_rd_t;
    logic [23:0]     r_rd_c;

    logic [CntW-1:0] mid;
    logic [16:0]     ydiff;
    logic            lt, eq;
    logic [CountAddrW-1:0] base_src, base_pos, caddr_rd;

    assign mid = r_lo + ((r_hi - r_lo) >> 1);
    assign lt = {r_rd_f, r_rd_m, r_rd_t} < {r_kf, r_km, r_kt};
    assign eq = {r_rd_f, r_rd_m, r_rd_t} == {r_kf, r_km, r_kt};
    assign ydiff = {1'b0, i_year} - {1'b0, i_base_year};
    assign base_src = CountAddrW'(r_src[PosW-1:0] * YearSlots);
    assign base_pos = CountAddrW'(r_lo[PosW-1:0] * YearSlots);
    assign caddr_rd = CountAddrW'(r_rpos * YearSlots) + CountAddrW'(r_rslot);

    // move whole entries slot by slot (read, then write); key fields with slot zero
    logic mv_last_slot;
    assign mv_last_slot = (r_sidx == SlotW'(YearSlots - 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_kf <= i_key_bytes_first;
            r_km <= i_key_bytes_middle;
            r_kt <= {i_key_bytes_last, i_sex_code};
            r_cnt <= i_count;
            r_rpos <= i_read_position;
            r_rslot <= i_read_slot;
            r_lo <= '0;
            r_hi <= r_used;
            r_found <= 1'b0;
            r_full <= (r_used >= CntW'(TableEntries));
            r_bad <= ydiff[16] || (ydiff[15:0] >= 16'(YearSlots));
            r_slot <= SlotW'(ydiff[15:0]);
            r_src <= r_used - CntW'(1);
            r_sidx <= '0;
        end
        if (i_cmd.probe_rd) begin
            r_rd_f <= r_mem_first[mid[PosW-1:0]];
            r_rd_m <= r_mem_mid[mid[PosW-1:0]];
            r_rd_t <= r_mem_tail[mid[PosW-1:0]];
        end
        if (i_cmd.probe_eval) begin
            if (eq) begin
                r_found <= 1'b1;
                r_lo <= mid;
                r_hi <= mid;
            end else if (lt) r_lo <= mid + CntW'(1);
            else r_hi <= mid;
        end
        if (i_cmd.shift_rd) begin
            r_rd_f <= r_mem_first[r_src[PosW-1:0]];
            r_rd_m <= r_mem_mid[r_src[PosW-1:0]];
            r_rd_t <= r_mem_tail[r_src[PosW-1:0]];
            r_rd_c <= r_mem_cnt[base_src + CountAddrW'(r_sidx)];
        end
        if (i_cmd.shift_wr) begin
            r_mem_cnt[base_src + CountAddrW'(YearSlots) + CountAddrW'(r_sidx)] <= r_rd_c;
            if (r_sidx == '0) begin
                r_mem_first[r_src[PosW-1:0] + PosW'(1)] <= r_rd_f;
                r_mem_mid[r_src[PosW-1:0] + PosW'(1)] <= r_rd_m;
                r_mem_tail[r_src[PosW-1:0] + PosW'(1)] <= r_rd_t;
            end
            if (mv_last_slot) begin
                r_sidx <= '0;
                r_src <= r_src - CntW'(1);
            end else r_sidx <= r_sidx + SlotW'(1);
        end
        if (i_cmd.clr_wr) begin
            r_mem_cnt[base_pos + CountAddrW'(r_sidx)] <= '0;
            r_sidx <= mv_last_slot ? '0 : r_sidx + SlotW'(1);
        end
        if (i_cmd.key_wr) begin
            r_mem_first[r_lo[PosW-1:0]] <= r_kf;
            r_mem_mid[r_lo[PosW-1:0]] <= r_km;
            r_mem_tail[r_lo[PosW-1:0]] <= r_kt;
        end
        if (i_cmd.upd_wr) r_mem_cnt[base_pos + CountAddrW'(r_slot)] <= r_cnt;
        if (i_cmd.rd_issue) begin
            r_rd_f <= r_mem_first[r_rpos];
            r_rd_m <= r_mem_mid[r_rpos];
            r_rd_t <= r_mem_tail[r_rpos];
            r_rd_c <= r_mem_cnt[caddr_rd];
            r_slot_ok <= (r_rslot < SlotW'(YearSlots));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_used <= '0;
        else if (i_cmd.key_wr) r_used <= r_used + CntW'(1);
    end

    assign o_stat.kind = r_kind;
    assign o_stat.search_done = (r_lo >= r_hi);
    assign o_stat.found = r_found;
    assign o_stat.bad_year = r_bad;
    assign o_stat.full = !r_found && r_full;
    assign o_stat.shift_last = mv_last_slot && (r_src == r_lo);
    assign o_stat.no_shift = (r_lo == r_used);
    assign o_stat.clr_last = mv_last_slot;

    logic rvalid;
    assign rvalid = ({1'b0, r_rpos} < r_used);

    // result outputs, valid while o_done is high
    assign o_done = i_cmd.finish;
    assign o_position = r_kind ? {1'b0, r_rpos} : r_lo;
    assign o_already_present = !r_kind && r_found;
    assign o_table_full = !r_kind && o_stat.full;
    assign o_year_out_of_range = !r_kind && r_bad;
    assign o_entry_valid = r_kind && rvalid;
    assign o_out_key_first = o_entry_valid ? r_rd_f : '0;
    assign o_out_key_middle = o_entry_valid ? r_rd_m : '0;
    assign o_out_key_last = o_entry_valid ? r_rd_t[31:8] : '0;
    assign o_out_sex = o_entry_valid ? r_rd_t[7:0] : '0;
    assign o_out_count = (o_entry_valid && r_slot_ok) ? r_rd_c : '0;
    assign o_entries_used = r_used;
endmodule
`default_nettype wire

>>> hw/rtl/sorted_key_table_insert_update.sv
// channel   direction  handshake
// request   in         start high while busy low
// result    out        o_done strobe, one cycle
// config    in         apb write at paddr 0 (base_year)
//
// a record runs a binary search (up to 11 probes: a read, then a compare);
// a hit writes its count, a flagged record goes to the result; an insert
// moves each count slot of later entries up (a read, then a write; ten per
// entry), clears ten slots, writes key, then count; a read fetches an entry.
// synchronous active-low reset empties the table; no clearing pass.
// results cannot be stalled; the next request is taken once busy drops.
`default_nettype none
module sorted_key_table_insert_update
    import skt_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [0:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_kind,
    input  wire logic [15:0] i_year,
    input  wire logic [63:0] i_key_bytes_first,
    input  wire logic [63:0] i_key_bytes_middle,
    input  wire logic [23:0] i_key_bytes_last,
    input  wire logic [7:0]  i_sex_code,
    input  wire logic [23:0] i_count,
    input  wire logic [9:0]  i_read_position,
    input  wire logic [3:0]  i_read_slot,
    output logic             o_done,
    output logic [10:0]      o_position,
    output logic             o_already_present,
    output logic             o_table_full,
    output logic             o_year_out_of_range,
    output logic [63:0]      o_out_key_first,
    output logic [63:0]      o_out_key_middle,
    output logic [23:0]      o_out_key_last,
    output logic [7:0]       o_out_sex,
    output logic [23:0]      o_out_count,
    output logic             o_entry_valid,
    output logic [10:0]      o_entries_used
);
`include "sorted_key_table_insert_update_assert.svh"

    logic [15:0] r_base_year;
    t_cmd  cmd;
    t_stat stat;

    // register file: only base_year at address 0
    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_base_year <= BaseYearReset;
        else if (psel && penable && pwrite && paddr == 1'b0) r_base_year <= pwdata[15:0];
    end
    assign prdata = (paddr == 1'b0) ? {16'd0, r_base_year} : 32'd0;

    skt_ctrl u_ctrl (
        .i_clk, .i_rst_n, .start, .busy, .i_stat(stat), .o_cmd(cmd)
    );

    skt_dp u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_stat(stat), .i_base_year(r_base_year),
        .i_kind, .i_year, .i_key_bytes_first, .i_key_bytes_middle, .i_key_bytes_last,
        .i_sex_code, .i_count, .i_read_position, .i_read_slot,
        .o_done, .o_position, .o_already_present, .o_table_full, .o_year_out_of_range,
        .o_out_key_first, .o_out_key_middle, .o_out_key_last, .o_out_sex,
        .o_out_count, .o_entry_valid, .o_entries_used
    );

    // entries never exceed capacity
    `SKT_ASSERT_ALWAYS(a_used_cap, i_clk, i_rst_n, o_entries_used <= 11'(TableEntries))
    // a request is always followed by busy
    `SKT_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy, busy)
    // result strobe ends the request
    `SKT_ASSERT_NEXT(a_done_idle, i_clk, i_rst_n, o_done, !busy)
endmodule
`default_nettype wire
